/* src/psrq_pkg.sv */
`timescale 1ns / 1ps
package psrq_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 11;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 42;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  // width for comparing positions against the element count
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_UPD_DIFF,
    ST_UPD_SWEEP,
    ST_QRY_LO,
    ST_QRY_SUB,
    ST_RESPOND
  } state_e;

  typedef struct packed {
    logic              val_re;
    logic              val_we;
    logic [ADDR_W-1:0] val_addr;
    logic [VAL_W-1:0]  val_wdata;
    logic              pre_re;
    logic [ADDR_W-1:0] pre_raddr;
    logic              pre_we;
    logic [ADDR_W-1:0] pre_waddr;
    logic [SUM_W-1:0]  pre_wdata;
  } mem_req_t;

  function automatic logic [SUM_W-1:0] sext_val(input logic [VAL_W-1:0] v);
    return {{(SUM_W - VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

/* src/psrq_req_if.sv */
`timescale 1ns / 1ps
interface psrq_req_if;
  logic                             valid;
  logic                             ready;
  logic [psrq_pkg::KIND_W-1:0]      kind;
  logic [psrq_pkg::POS_W-1:0]       first_position;
  logic [psrq_pkg::POS_W-1:0]       last_position;
  logic signed [psrq_pkg::VAL_W-1:0] item_value;

  modport source (output valid, kind, first_position, last_position, item_value,
                  input ready);
  modport sink (input valid, kind, first_position, last_position, item_value,
                output ready);
endinterface

/* src/psrq_rsp_if.sv */
`timescale 1ns / 1ps
interface psrq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [psrq_pkg::SUM_W-1:0] range_sum;
  logic [psrq_pkg::STAT_W-1:0]       status;

  modport source (output valid, range_sum, status, input ready);
  modport sink (input valid, range_sum, status, output ready);
endinterface

/* src/psrq_mem.sv */
`timescale 1ns / 1ps
module psrq_mem (
  input  logic                           clk,
  input  psrq_pkg::mem_req_t             mreq,
  output logic [psrq_pkg::VAL_W-1:0]     val_rdata,
  output logic [psrq_pkg::SUM_W-1:0]     pre_rdata
);

  logic [psrq_pkg::VAL_W-1:0] value_store  [psrq_pkg::DEPTH];
  logic [psrq_pkg::SUM_W-1:0] prefix_store [psrq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.val_we) begin
      value_store[mreq.val_addr] <= mreq.val_wdata;
    end
    if (mreq.val_re) begin
      val_rdata <= value_store[mreq.val_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.pre_we) begin
      prefix_store[mreq.pre_waddr] <= mreq.pre_wdata;
    end
    if (mreq.pre_re) begin
      pre_rdata <= prefix_store[mreq.pre_raddr];
    end
  end

endmodule

/* src/psrq_ctrl.sv */
`timescale 1ns / 1ps
module psrq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  psrq_req_if.sink                   req,
  psrq_rsp_if.source                 rsp,
  output psrq_pkg::mem_req_t         mreq,
  input  logic [psrq_pkg::VAL_W-1:0] val_rdata,
  input  logic [psrq_pkg::SUM_W-1:0] pre_rdata
);

  localparam int CMP_W  = psrq_pkg::CMP_W;
  localparam int ADDR_W = psrq_pkg::ADDR_W;
  localparam int CNT_W  = psrq_pkg::CNT_W;
  localparam int SUM_W  = psrq_pkg::SUM_W;
  localparam int VAL_W  = psrq_pkg::VAL_W;
  localparam int POS_W  = psrq_pkg::POS_W;

  psrq_pkg::state_e  state, state_next;
  logic [CNT_W-1:0]  count;
  logic [VAL_W-1:0]  val_reg;
  logic [POS_W-1:0]  first_reg;
  logic [SUM_W-1:0]  diff;
  logic [SUM_W-1:0]  hi_sum;
  logic [ADDR_W-1:0] sweep_addr;
  logic [SUM_W-1:0]  res_sum;
  psrq_pkg::status_e res_status;
  psrq_pkg::status_e acc_status;
  logic              out_valid;
  logic [SUM_W-1:0]  out_sum;
  psrq_pkg::status_e out_status;

  logic             accept;
  logic             slot_free;
  logic [CMP_W-1:0] first_c, last_c, cnt_c, first_reg_c;
  logic             full, upd_ok, qry_ok, sweep_more, need_lo;

  assign req.ready     = (state == psrq_pkg::ST_IDLE);
  assign accept        = req.valid && req.ready;
  assign slot_free     = !out_valid || rsp.ready;
  assign rsp.valid     = out_valid;
  assign rsp.range_sum = out_sum;
  assign rsp.status    = out_status;

  assign first_c     = CMP_W'(req.first_position);
  assign last_c      = CMP_W'(req.last_position);
  assign cnt_c       = CMP_W'(count);
  assign first_reg_c = CMP_W'(first_reg);
  assign full        = (cnt_c == CMP_W'(psrq_pkg::DEPTH));
  assign upd_ok      = (first_c != '0) && (first_c <= cnt_c);
  assign qry_ok      = (first_c != '0) && (last_c >= first_c) && (last_c <= cnt_c);
  assign sweep_more  = (CMP_W'(sweep_addr) + CMP_W'(1)) < cnt_c;
  assign need_lo     = first_reg_c >= CMP_W'(2);

  always_comb begin
    acc_status = psrq_pkg::STATUS_BAD_POS;
    case (req.kind)
      psrq_pkg::KIND_LOAD: begin
        acc_status = full ? psrq_pkg::STATUS_FULL : psrq_pkg::STATUS_OK;
      end
      psrq_pkg::KIND_UPDATE: begin
        acc_status = upd_ok ? psrq_pkg::STATUS_OK : psrq_pkg::STATUS_BAD_POS;
      end
      psrq_pkg::KIND_QUERY: begin
        acc_status = qry_ok ? psrq_pkg::STATUS_OK : psrq_pkg::STATUS_BAD_POS;
      end
      default: begin
        acc_status = psrq_pkg::STATUS_BAD_POS;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      psrq_pkg::ST_IDLE: begin
        if (accept) begin
          if (acc_status != psrq_pkg::STATUS_OK) begin
            state_next = psrq_pkg::ST_RESPOND;
          end else begin
            case (req.kind)
              psrq_pkg::KIND_LOAD:   state_next = psrq_pkg::ST_LOAD_WR;
              psrq_pkg::KIND_UPDATE: state_next = psrq_pkg::ST_UPD_DIFF;
              psrq_pkg::KIND_QUERY:  state_next = psrq_pkg::ST_QRY_LO;
              default:               state_next = psrq_pkg::ST_RESPOND;
            endcase
          end
        end
      end
      psrq_pkg::ST_LOAD_WR:   state_next = psrq_pkg::ST_RESPOND;
      psrq_pkg::ST_UPD_DIFF:  state_next = psrq_pkg::ST_UPD_SWEEP;
      psrq_pkg::ST_UPD_SWEEP: begin
        if (!sweep_more) begin
          state_next = psrq_pkg::ST_RESPOND;
        end
      end
      psrq_pkg::ST_QRY_LO: begin
        state_next = need_lo ? psrq_pkg::ST_QRY_SUB : psrq_pkg::ST_RESPOND;
      end
      psrq_pkg::ST_QRY_SUB:   state_next = psrq_pkg::ST_RESPOND;
      psrq_pkg::ST_RESPOND: begin
        if (slot_free) begin
          state_next = psrq_pkg::ST_IDLE;
        end
      end
      default: state_next = psrq_pkg::ST_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    mreq = '0;
    case (state)
      psrq_pkg::ST_IDLE: begin
        if (accept && acc_status == psrq_pkg::STATUS_OK) begin
          case (req.kind)
            psrq_pkg::KIND_LOAD: begin
              mreq.pre_re    = (count != '0);
              mreq.pre_raddr = ADDR_W'(count - CNT_W'(1));
            end
            psrq_pkg::KIND_UPDATE: begin
              mreq.val_re   = 1'b1;
              mreq.val_addr = ADDR_W'(req.first_position - POS_W'(1));
            end
            psrq_pkg::KIND_QUERY: begin
              mreq.pre_re    = 1'b1;
              mreq.pre_raddr = ADDR_W'(req.last_position - POS_W'(1));
            end
            default: begin
              mreq.pre_re = 1'b0;
            end
          endcase
        end
      end
      psrq_pkg::ST_LOAD_WR: begin
        mreq.val_we    = 1'b1;
        mreq.val_addr  = ADDR_W'(count);
        mreq.val_wdata = val_reg;
        mreq.pre_we    = 1'b1;
        mreq.pre_waddr = ADDR_W'(count);
        mreq.pre_wdata = ((count == '0) ? '0 : pre_rdata) + psrq_pkg::sext_val(val_reg);
      end
      psrq_pkg::ST_UPD_DIFF: begin
        mreq.val_we    = 1'b1;
        mreq.val_addr  = ADDR_W'(first_reg - POS_W'(1));
        mreq.val_wdata = val_reg;
        mreq.pre_re    = 1'b1;
        mreq.pre_raddr = ADDR_W'(first_reg - POS_W'(1));
      end
      psrq_pkg::ST_UPD_SWEEP: begin
        // write entry read last cycle, fetch the one after it
        mreq.pre_we    = 1'b1;
        mreq.pre_waddr = sweep_addr;
        mreq.pre_wdata = pre_rdata + diff;
        mreq.pre_re    = sweep_more;
        mreq.pre_raddr = sweep_addr + ADDR_W'(1);
      end
      psrq_pkg::ST_QRY_LO: begin
        mreq.pre_re    = need_lo;
        mreq.pre_raddr = ADDR_W'(first_reg - POS_W'(2));
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psrq_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == psrq_pkg::ST_LOAD_WR) begin
        count <= count + CNT_W'(1);
      end
      if (state == psrq_pkg::ST_RESPOND && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_reg    <= req.item_value;
      first_reg  <= req.first_position;
      res_sum    <= '0;
      res_status <= acc_status;
    end
    case (state)
      psrq_pkg::ST_UPD_DIFF: begin
        diff       <= psrq_pkg::sext_val(val_reg) - psrq_pkg::sext_val(val_rdata);
        sweep_addr <= ADDR_W'(first_reg - POS_W'(1));
      end
      psrq_pkg::ST_UPD_SWEEP: begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end
      psrq_pkg::ST_QRY_LO: begin
        if (need_lo) begin
          hi_sum <= pre_rdata;
        end else begin
          res_sum <= pre_rdata;
        end
      end
      psrq_pkg::ST_QRY_SUB: begin
        res_sum <= hi_sum - pre_rdata;
      end
      psrq_pkg::ST_RESPOND: begin
        if (slot_free) begin
          out_sum    <= res_sum;
          out_status <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/prefix_sum_range_query.sv */
`timescale 1ns / 1ps
// channel  role    handshake      payload
// req      sink    valid/ready    kind, first_position, last_position, item_value
// rsp      source  valid/ready    range_sum, status
//
// One item at a time. A load passes ST_LOAD_WR; a query passes ST_QRY_LO and,
// if first_position >= 2, ST_QRY_SUB; an error goes straight to ST_RESPOND.
// An update at p sweeps prefix entries p..count, one entry per cycle on its
// single write port. Reset (rst, synchronous) clears the control state and the
// element count; the memories are not cleared. A result waits in the output
// register while rsp is stalled; the next item is taken in the meantime.
module prefix_sum_range_query (
  input logic        clk,
  input logic        rst,
  psrq_req_if.sink   req,
  psrq_rsp_if.source rsp
);

  psrq_pkg::mem_req_t         mreq;
  logic [psrq_pkg::VAL_W-1:0] val_rdata;
  logic [psrq_pkg::SUM_W-1:0] pre_rdata;

  psrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mreq      (mreq),
    .val_rdata (val_rdata),
    .pre_rdata (pre_rdata)
  );

  psrq_mem u_mem (
    .clk       (clk),
    .mreq      (mreq),
    .val_rdata (val_rdata),
    .pre_rdata (pre_rdata)
  );

  // sweep never reads the entry it writes back
  a_pre_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (mreq.pre_we && mreq.pre_re) |-> (mreq.pre_waddr != mreq.pre_raddr))
    else $error("prefix read and write hit the same entry");

  a_val_single_access: assert property (@(posedge clk) disable iff (rst)
    !(mreq.val_re && mreq.val_we))
    else $error("value memory read and written in one cycle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item taken while another is in flight");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !(mreq.pre_we || mreq.val_we))
    else $error("memory write while idle");

endmodule
